@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the top level RTL of the patch neighbour test.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define OPN_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define OPN_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define OPN_ASSERT(lbl, clk, rst, prop)
`define OPN_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ hw/rtl/opnt_pkg.sv @@
// Shared constants, types and the square root step of the patch neighbour test.
`timescale 1ns / 1ps
package opnt_pkg;

   // Default parameter values
   localparam int COORD_BITS_DEF  = 24;
   localparam int NORMAL_BITS_DEF = 16;

   // Fixed field widths
   localparam int SCALE_W  = 16;
   localparam int THRESH_W = 16;
   localparam int RADIUS_W = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RADIUS    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RAD_EN    = 2'd2;

   // Reset values
   localparam logic [THRESH_W-1:0] THRESHOLD_RST = 16'd128;

   // Verdict codes
   localparam logic [1:0] VERDICT_NEIGHBOR = 2'd0;
   localparam logic [1:0] VERDICT_OPPOSED  = 2'd1;
   localparam logic [1:0] VERDICT_RADIUS   = 2'd2;
   localparam logic [1:0] VERDICT_VERTICAL = 2'd3;

   // Square root: the root is only needed below 16 * cell^2 < 2^36
   localparam int SQ_IN_W   = 2 * SCALE_W + 4;
   localparam int SQ_RW     = SQ_IN_W + 1;
   localparam int ROOT_W    = SQ_IN_W / 2;
   localparam int SQ_STAGES = ROOT_W / 2;

   typedef struct packed {
      logic [SQ_RW-1:0] rem;
      logic [SQ_RW-1:0] root;
   } sq_pair_type;

   // One digit of the bitwise square root
   function automatic sq_pair_type sqrt_step(input sq_pair_type p, input int unsigned idx);
      logic [SQ_RW-1:0] bit_v;
      logic [SQ_RW-1:0] trial;
      sq_pair_type      q;
      bit_v = {{(SQ_RW-1){1'b0}}, 1'b1} << (SQ_IN_W - 2 - 2 * idx);
      trial = p.root + bit_v;
      if (p.rem >= trial) begin
         q.rem  = p.rem - trial;
         q.root = (p.root >> 1) + bit_v;
      end else begin
         q.rem  = p.rem;
         q.root = p.root >> 1;
      end
      return q;
   endfunction

endpackage

@@ hw/rtl/opnt_isqrt_pipe.sv @@
// Pipelined integer square root, two root bits per stage.
`timescale 1ns / 1ps
module opnt_isqrt_pipe
   import opnt_pkg::*;
(
   input  logic                 clock,
   input  logic [SQ_STAGES-1:0] stage_en,
   input  logic [SQ_IN_W-1:0]   value_in,
   output logic [ROOT_W-1:0]    root_out
);

   sq_pair_type stage_ff [SQ_STAGES];

   for (genvar j = 0; j < SQ_STAGES; j++) begin : g_stage
      sq_pair_type src;
      sq_pair_type mid;
      sq_pair_type stage_in;

      // take the previous partial result
      if (j == 0) begin : g_first
         assign src = {SQ_RW'(value_in), {SQ_RW{1'b0}}};
      end else begin : g_next
         assign src = stage_ff[j-1];
      end

      // two digits a stage
      always_comb begin
         mid      = sqrt_step(src, 2 * j);
         stage_in = sqrt_step(mid, 2 * j + 1);
      end

      // hold while the stage stalls
      always_ff @(posedge clock) begin
         if (stage_en[j]) begin
            stage_ff[j] <= stage_in;
         end
      end
   end

   assign root_out = stage_ff[SQ_STAGES-1].root[ROOT_W-1:0];

endmodule

@@ hw/rtl/oriented_patch_neighbor_test.sv @@
// Top level of the oriented patch neighbour test pipeline.
//
// Channel | Direction | Ports                           | Beat
// req     | in        | req_valid/req_ready + fields    | one patch pair
// rsp     | out       | rsp_valid/rsp_ready + fields    | one verdict
// csr     | in        | csr_valid/csr_ready, index/data | one register write
//
// One pair a cycle while rsp_ready is high; 8 arithmetic stages, 9 square root
// stages (two root bits each), one product stage and the output register.
// Reset clears all valid bits and loads the register defaults.
// Each stage holds only while the stage after it is full and held, so bubbles
// close up and a held result stops new beats only once every stage is full.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module oriented_patch_neighbor_test
   import opnt_pkg::*;
#(
   parameter int COORD_BITS  = COORD_BITS_DEF,
   parameter int NORMAL_BITS = NORMAL_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_BITS-1:0]  req_first_x,
   input  logic signed [COORD_BITS-1:0]  req_first_y,
   input  logic signed [COORD_BITS-1:0]  req_first_z,
   input  logic [3*NORMAL_BITS-1:0]      req_first_normal,
   input  logic [SCALE_W-1:0]            req_first_depth_scale,
   input  logic signed [COORD_BITS-1:0]  req_second_x,
   input  logic signed [COORD_BITS-1:0]  req_second_y,
   input  logic signed [COORD_BITS-1:0]  req_second_z,
   input  logic [3*NORMAL_BITS-1:0]      req_second_normal,
   input  logic [SCALE_W-1:0]            req_second_depth_scale,
   input  logic [SCALE_W-1:0]            req_cell_unit,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_is_neighbor,
   output logic [1:0]                    rsp_verdict,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_data
);

   localparam int CB    = COORD_BITS;
   localparam int NB    = NORMAL_BITS;
   localparam int FN    = NB - 2;
   localparam int DW    = CB + 1;
   localparam int PNW   = NB + DW;
   localparam int FW    = PNW + 2;
   localparam int DOTW  = 2 * NB + 2;
   localparam int FRW   = FW - FN;
   localparam int QW    = NB + FRW;
   localparam int FULLW = QW + 2;
   localparam int HQW   = FULLW - FN;
   localparam int MW    = (HQW > 32) ? HQW : 32;
   localparam int SW    = FW + 9 - FN;
   localparam int VW    = SCALE_W + 1;
   localparam int VTW   = VW + THRESH_W;
   localparam int CW    = (SW > VTW + 2) ? SW : VTW + 2;
   localparam int SUW   = SW + SCALE_W;
   localparam int TVHW  = VTW + ROOT_W;
   localparam int PW    = (SUW > TVHW) ? SUW : TVHW;
   localparam int HSQW  = 63;
   localparam int SQ0   = 8;
   localparam int NST   = SQ0 + SQ_STAGES + 2;

   localparam logic [DOTW-1:0] DOT_HALF = {{(DOTW-1){1'b0}}, 1'b1} << (2 * FN - 1);
   localparam logic [HSQW-1:0] HSQ_CAP  = {1'b1, {(HSQW-1){1'b0}}};

   typedef struct packed {
      logic              opp;
      logic              rad;
      logic              vz;
      logic              le;
      logic              ge;
      logic [SW-1:0]     s;
      logic [SCALE_W-1:0] u;
      logic [VTW-1:0]    vt;
   } side_type;

   // Configuration registers
   logic [THRESH_W-1:0]   thresh_ff;
   logic [RADIUS_W-1:0]   radius_ff;
   logic                  rad_en_ff;
   logic [2*RADIUS_W-1:0] r_sq_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESHOLD_RST;
         radius_ff <= '0;
         rad_en_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_THRESHOLD: thresh_ff <= csr_data[THRESH_W-1:0];
            REG_RADIUS:    radius_ff <= csr_data[RADIUS_W-1:0];
            REG_RAD_EN:    rad_en_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // radius square follows the register
   always_ff @(posedge clock) begin
      r_sq_ff <= radius_ff * radius_ff;
   end

   // Stall control: a stage loads when empty or when its content moves on
   logic [NST-1:0] vld_ff;
   logic [NST-1:0] vld_src;
   logic [NST:0]   go;

   assign vld_src = {vld_ff[NST-2:0], req_valid};

   always_comb begin
      go[NST] = rsp_ready;
      for (int k = NST - 1; k >= 0; k--) begin
         go[k] = !vld_ff[k] || go[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NST; k++) begin
            if (go[k]) begin
               vld_ff[k] <= vld_src[k];
            end
         end
      end
   end

   assign req_ready = go[0];

   // Stage 0: unpack normals, form the offset and the depth sum
   logic signed [CB-1:0] a_c [3];
   logic signed [CB-1:0] b_c [3];
   logic signed [DW-1:0] d0_ff [3];
   logic signed [NB-1:0] n1_0_ff [3];
   logic signed [NB-1:0] n2_0_ff [3];
   logic [VW-1:0]        v0_ff;
   logic [SCALE_W-1:0]   u0_ff;

   always_comb begin
      a_c[0] = req_first_x;
      a_c[1] = req_first_y;
      a_c[2] = req_first_z;
      b_c[0] = req_second_x;
      b_c[1] = req_second_y;
      b_c[2] = req_second_z;
   end

   always_ff @(posedge clock) begin
      if (go[0]) begin
         for (int k = 0; k < 3; k++) begin
            d0_ff[k]   <= DW'(b_c[k]) - DW'(a_c[k]);
            n1_0_ff[k] <= $signed(req_first_normal[k*NB +: NB]);
            n2_0_ff[k] <= $signed(req_second_normal[k*NB +: NB]);
         end
         v0_ff <= VW'(req_first_depth_scale) + VW'(req_second_depth_scale);
         u0_ff <= req_cell_unit;
      end
   end

   // Stage 1: element products
   logic signed [2*NB-1:0] pnn1_ff [3];
   logic signed [PNW-1:0]  p1d1_ff [3];
   logic signed [PNW-1:0]  p2d1_ff [3];
   logic signed [DW-1:0]   d1_ff [3];
   logic signed [NB-1:0]   n1_1_ff [3];
   logic signed [NB-1:0]   n2_1_ff [3];
   logic [VW-1:0]          v1_ff;
   logic [SCALE_W-1:0]     u1_ff;

   always_ff @(posedge clock) begin
      if (go[1]) begin
         for (int k = 0; k < 3; k++) begin
            pnn1_ff[k] <= n1_0_ff[k] * n2_0_ff[k];
            p1d1_ff[k] <= PNW'(n1_0_ff[k]) * PNW'(d0_ff[k]);
            p2d1_ff[k] <= PNW'(n2_0_ff[k]) * PNW'(d0_ff[k]);
         end
         d1_ff   <= d0_ff;
         n1_1_ff <= n1_0_ff;
         n2_1_ff <= n2_0_ff;
         v1_ff   <= v0_ff;
         u1_ff   <= u0_ff;
      end
   end

   // Stage 2: dot products
   logic signed [DOTW-1:0] dot2_ff;
   logic signed [FW-1:0]   f0_2_ff;
   logic signed [FW-1:0]   f1_2_ff;
   logic signed [DW-1:0]   d2_ff [3];
   logic signed [NB-1:0]   n1_2_ff [3];
   logic signed [NB-1:0]   n2_2_ff [3];
   logic [VW-1:0]          v2_ff;
   logic [SCALE_W-1:0]     u2_ff;

   always_ff @(posedge clock) begin
      if (go[2]) begin
         dot2_ff <= DOTW'(pnn1_ff[0]) + DOTW'(pnn1_ff[1]) + DOTW'(pnn1_ff[2]);
         f0_2_ff <= FW'(p1d1_ff[0]) + FW'(p1d1_ff[1]) + FW'(p1d1_ff[2]);
         f1_2_ff <= FW'(p2d1_ff[0]) + FW'(p2d1_ff[1]) + FW'(p2d1_ff[2]);
         d2_ff   <= d1_ff;
         n1_2_ff <= n1_1_ff;
         n2_2_ff <= n2_1_ff;
         v2_ff   <= v1_ff;
         u2_ff   <= u1_ff;
      end
   end

   // Stage 3: normal angle, vertical measure, projections back onto the normals
   logic [FW-1:0]         f0_mag;
   logic [FW-1:0]         f1_mag;
   logic [FW:0]           f_sum;
   logic signed [FRW-1:0] f0r;
   logic signed [FRW-1:0] f1r;
   logic                  opp3_ff;
   logic [SW-1:0]         s3_ff;
   logic signed [QW-1:0]  q1_3_ff [3];
   logic signed [QW-1:0]  q2_3_ff [3];
   logic signed [DW-1:0]  d3_ff [3];
   logic [VW-1:0]         v3_ff;
   logic [SCALE_W-1:0]    u3_ff;

   always_comb begin
      f0_mag = f0_2_ff[FW-1] ? FW'(-f0_2_ff) : FW'(f0_2_ff);
      f1_mag = f1_2_ff[FW-1] ? FW'(-f1_2_ff) : FW'(f1_2_ff);
      f_sum  = (FW+1)'(f0_mag) + (FW+1)'(f1_mag);
      f0r    = f0_2_ff[FW-1:FN];
      f1r    = f1_2_ff[FW-1:FN];
   end

   always_ff @(posedge clock) begin
      if (go[3]) begin
         opp3_ff <= dot2_ff < -$signed(DOT_HALF);
         s3_ff   <= f_sum[FW:FN-8];
         for (int k = 0; k < 3; k++) begin
            q1_3_ff[k] <= QW'(n1_2_ff[k]) * QW'(f0r);
            q2_3_ff[k] <= QW'(n2_2_ff[k]) * QW'(f1r);
         end
         d3_ff <= d2_ff;
         v3_ff <= v2_ff;
         u3_ff <= u2_ff;
      end
   end

   // Stage 4: horizontal parts and their magnitudes
   logic signed [FULLW-1:0] full_c [3];
   logic signed [HQW-1:0]   hq_c [3];
   logic [MW-1:0]           mx_c [3];
   logic [30:0]             ms4_ff [3];
   logic                    sat4_ff;
   logic                    opp4_ff;
   logic [SW-1:0]           s4_ff;
   logic [VW-1:0]           v4_ff;
   logic [SCALE_W-1:0]      u4_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         full_c[k] = (FULLW'(d3_ff[k]) <<< (FN + 1)) - FULLW'(q1_3_ff[k])
                     - FULLW'(q2_3_ff[k]);
         hq_c[k]   = full_c[k][FULLW-1:FN];
         mx_c[k]   = hq_c[k][HQW-1] ? MW'(HQW'(-hq_c[k])) : MW'(HQW'(hq_c[k]));
      end
   end

   always_ff @(posedge clock) begin
      if (go[4]) begin
         for (int k = 0; k < 3; k++) begin
            ms4_ff[k] <= mx_c[k][30:0];
         end
         sat4_ff <= (|mx_c[0][MW-1:31]) || (|mx_c[1][MW-1:31]) || (|mx_c[2][MW-1:31]);
         opp4_ff <= opp3_ff;
         s4_ff   <= s3_ff;
         v4_ff   <= v3_ff;
         u4_ff   <= u3_ff;
      end
   end

   // Stage 5: squares
   logic [61:0]        sq5_ff [3];
   logic               sat5_ff;
   logic               opp5_ff;
   logic [SW-1:0]      s5_ff;
   logic [VW-1:0]      v5_ff;
   logic [SCALE_W-1:0] u5_ff;

   always_ff @(posedge clock) begin
      if (go[5]) begin
         for (int k = 0; k < 3; k++) begin
            sq5_ff[k] <= 62'(ms4_ff[k]) * 62'(ms4_ff[k]);
         end
         sat5_ff <= sat4_ff;
         opp5_ff <= opp4_ff;
         s5_ff   <= s4_ff;
         v5_ff   <= v4_ff;
         u5_ff   <= u4_ff;
      end
   end

   // Stage 6: squared gap with saturation, cell unit square
   logic [63:0]          hsum;
   logic [HSQW-1:0]      hsq6_ff;
   logic [2*SCALE_W-1:0] uu6_ff;
   logic                 opp6_ff;
   logic [SW-1:0]        s6_ff;
   logic [VW-1:0]        v6_ff;
   logic [SCALE_W-1:0]   u6_ff;

   assign hsum = 64'(sq5_ff[0]) + 64'(sq5_ff[1]) + 64'(sq5_ff[2]);

   always_ff @(posedge clock) begin
      if (go[6]) begin
         hsq6_ff <= (sat5_ff || hsum > 64'(HSQ_CAP)) ? HSQ_CAP : hsum[HSQW-1:0];
         uu6_ff  <= u5_ff * u5_ff;
         opp6_ff <= opp5_ff;
         s6_ff   <= s5_ff;
         v6_ff   <= v5_ff;
         u6_ff   <= u5_ff;
      end
   end

   // Stage 7: radius and cell range decisions, clamp for the root
   side_type           side7_ff;
   logic [SQ_IN_W-1:0] hs7_ff;

   always_ff @(posedge clock) begin
      if (go[7]) begin
         side7_ff.opp <= opp6_ff;
         side7_ff.rad <= rad_en_ff && (HSQW'({r_sq_ff, 2'b00}) < hsq6_ff);
         side7_ff.vz  <= v6_ff == '0;
         side7_ff.le  <= hsq6_ff <= HSQW'({uu6_ff, 2'b00});
         side7_ff.ge  <= hsq6_ff >= HSQW'({uu6_ff, 4'b0000});
         side7_ff.s   <= s6_ff;
         side7_ff.u   <= u6_ff;
         side7_ff.vt  <= VTW'(v6_ff) * VTW'(thresh_ff);
         hs7_ff       <= (|hsq6_ff[HSQW-1:SQ_IN_W]) ? {SQ_IN_W{1'b1}}
                                                     : hsq6_ff[SQ_IN_W-1:0];
      end
   end

   // Square root of the gap, side data rides alongside
   logic [ROOT_W-1:0] root;
   side_type          side_ff [SQ_STAGES];

   opnt_isqrt_pipe u_isqrt (
      .clock    (clock),
      .stage_en (go[SQ0 +: SQ_STAGES]),
      .value_in (hs7_ff),
      .root_out (root)
   );

   for (genvar j = 0; j < SQ_STAGES; j++) begin : g_side
      if (j == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (go[SQ0]) begin
               side_ff[0] <= side7_ff;
            end
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            if (go[SQ0+j]) begin
               side_ff[j] <= side_ff[j-1];
            end
         end
      end
   end

   // Product stage: cross products and bound compares
   side_type       sd;
   logic [CW-1:0]  s_cmp;
   logic [CW-1:0]  vt2_cmp;
   logic [CW-1:0]  vt4_cmp;
   logic           opp_p_ff;
   logic           rad_p_ff;
   logic           vz_p_ff;
   logic           le_p_ff;
   logic           ge_p_ff;
   logic           lt2_p_ff;
   logic           lt4_p_ff;
   logic [SUW-1:0] su_p_ff;
   logic [TVHW-1:0] tvh_p_ff;

   always_comb begin
      sd      = side_ff[SQ_STAGES-1];
      s_cmp   = CW'(sd.s);
      vt2_cmp = CW'({sd.vt, 1'b0});
      vt4_cmp = CW'({sd.vt, 2'b00});
   end

   always_ff @(posedge clock) begin
      if (go[NST-2]) begin
         opp_p_ff <= sd.opp;
         rad_p_ff <= sd.rad;
         vz_p_ff  <= sd.vz;
         le_p_ff  <= sd.le;
         ge_p_ff  <= sd.ge;
         lt2_p_ff <= s_cmp < vt2_cmp;
         lt4_p_ff <= s_cmp < vt4_cmp;
         su_p_ff  <= SUW'(sd.s) * SUW'(sd.u);
         tvh_p_ff <= TVHW'(sd.vt) * TVHW'(root);
      end
   end

   // Output register: pick the verdict in check order
   logic [1:0] verdict_in;
   logic [1:0] verdict_ff;

   always_comb begin
      if (opp_p_ff) begin
         verdict_in = VERDICT_OPPOSED;
      end else if (rad_p_ff) begin
         verdict_in = VERDICT_RADIUS;
      end else if (vz_p_ff) begin
         verdict_in = VERDICT_VERTICAL;
      end else if (le_p_ff) begin
         verdict_in = lt2_p_ff ? VERDICT_NEIGHBOR : VERDICT_VERTICAL;
      end else if (ge_p_ff || !lt4_p_ff) begin
         verdict_in = lt4_p_ff ? VERDICT_NEIGHBOR : VERDICT_VERTICAL;
      end else begin
         verdict_in = (PW'(su_p_ff) < PW'(tvh_p_ff)) ? VERDICT_NEIGHBOR
                                                     : VERDICT_VERTICAL;
      end
   end

   always_ff @(posedge clock) begin
      if (go[NST-1]) begin
         verdict_ff <= verdict_in;
      end
   end

   assign rsp_valid       = vld_ff[NST-1];
   assign rsp_verdict     = verdict_ff;
   assign rsp_is_neighbor = verdict_ff == VERDICT_NEIGHBOR;

   // Checks on the stall chain
   `OPN_ASSERT_NEXT(a_take_lands, clock, reset, req_valid && req_ready, vld_ff[0])
   `OPN_ASSERT(a_empty_takes, clock, reset, !vld_ff[0] |-> req_ready)
   `OPN_ASSERT(a_full_holds, clock, reset, (rsp_valid && !rsp_ready && (&vld_ff)) |-> !req_ready)

endmodule
